// ===== rtl/http_request_tokenizer_core_assert.svh =====
// assertion macros for the http request tokenizer
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef HTTP_REQUEST_TOKENIZER_CORE_ASSERT_SVH
`define HTTP_REQUEST_TOKENIZER_CORE_ASSERT_SVH

// property checked on every clock, held off while in reset
`define HTTPTOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock, reset included
`define HTTPTOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/httptok_pkg.sv =====
// shared types and constants for the http request tokenizer
// no dependencies
package httptok_pkg;

  // special characters
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;

  // token class codes
  localparam logic [2:0] ClsMethod  = 3'd0;
  localparam logic [2:0] ClsPath    = 3'd1;
  localparam logic [2:0] ClsVersion = 3'd2;
  localparam logic [2:0] ClsName    = 3'd3;
  localparam logic [2:0] ClsValue   = 3'd4;
  localparam logic [2:0] ClsSep     = 3'd5;
  localparam logic [2:0] ClsBody    = 3'd6;

  // parse phase, one-hot
  typedef enum logic [9:0] {
    PhMethod    = 10'b00_0000_0001,
    PhPath      = 10'b00_0000_0010,
    PhVersion   = 10'b00_0000_0100,
    PhLineLf    = 10'b00_0000_1000,
    PhLineStart = 10'b00_0001_0000,
    PhName      = 10'b00_0010_0000,
    PhColonSkip = 10'b00_0100_0000,
    PhValue     = 10'b00_1000_0000,
    PhBlankLf   = 10'b01_0000_0000,
    PhBody      = 10'b10_0000_0000
  } phase_e;

  // classifier result for one byte
  typedef struct packed {
    logic [2:0] cls;
    logic       first;
    logic       incomplete;
    phase_e     next_phase;
  } tok_res_t;

endpackage

// ===== rtl/httptok_classify.sv =====
// per-byte classifier: token class, token start, incomplete flag and next parse phase
// depends on httptok_pkg
module httptok_classify (
  input  httptok_pkg::phase_e   phase_i,
  input  logic                  token_open_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output httptok_pkg::tok_res_t res_o
);
  import httptok_pkg::*;

  logic [2:0] cls;
  phase_e     next_phase;

  // phase transition and class of this byte
  always_comb begin
    cls        = ClsSep;
    next_phase = phase_i;
    case (phase_i)
      PhPath: begin
        if (byte_i == ChSpace) begin
          next_phase = PhVersion;
        end else begin
          cls = ClsPath;
        end
      end
      PhVersion: begin
        if (byte_i == ChCr) begin
          next_phase = PhLineLf;
        end else begin
          cls = ClsVersion;
        end
      end
      PhLineLf: begin
        next_phase = PhLineStart;
      end
      PhLineStart: begin
        if (byte_i == ChCr) begin
          next_phase = PhBlankLf;
        end else if (byte_i == ChColon) begin
          next_phase = PhColonSkip;
        end else begin
          cls        = ClsName;
          next_phase = PhName;
        end
      end
      PhName: begin
        if (byte_i == ChColon) begin
          next_phase = PhColonSkip;
        end else if (byte_i == ChCr) begin
          next_phase = PhLineLf;
        end else begin
          cls = ClsName;
        end
      end
      PhColonSkip: begin
        next_phase = (byte_i == ChCr) ? PhLineLf : PhValue;
      end
      PhValue: begin
        if (byte_i == ChCr) begin
          next_phase = PhLineLf;
        end else begin
          cls = ClsValue;
        end
      end
      PhBlankLf: begin
        next_phase = PhBody;
      end
      PhBody: begin
        cls = ClsBody;
      end
      default: begin
        // method phase, and any stray code
        if (byte_i == ChSpace) begin
          next_phase = PhPath;
        end else begin
          cls        = ClsMethod;
          next_phase = PhMethod;
        end
      end
    endcase
  end

  // pack result; separators never start a token
  always_comb begin
    res_o.cls        = cls;
    res_o.first      = (cls != ClsSep) && !token_open_i;
    res_o.incomplete = last_i && (next_phase != PhBody);
    res_o.next_phase = next_phase;
  end

endmodule

// ===== rtl/http_request_tokenizer_core.sv =====
// Labels each byte of an HTTP request as method, path, version, header name,
// header value, separator or body. Throughput is one byte per clock while the
// output is not stalled; a byte is held in the input register after its
// transfer, then classified into the result register. The rate is set by the
// update of the parse phase, which advances as each byte leaves the input
// register. The byte marked last returns the parser to the method phase.
// depends on httptok_pkg, httptok_classify and http_request_tokenizer_core_assert.svh
module http_request_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] token_class_o,
  output logic       token_first_o,
  output logic       out_last_o,
  output logic       incomplete_o
);
  import httptok_pkg::*;

  `include "http_request_tokenizer_core_assert.svh"

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  phase_e     phase_q;
  phase_e     phase_d;
  logic       token_open_q;
  logic       token_open_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_cls_q;
  logic       out_first_q;
  logic       out_last_q;
  logic       out_inc_q;
  logic       out_free;
  logic       s1_move;
  logic       in_xfer;
  tok_res_t   res;

  // pipeline handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

  httptok_classify u_classify (
    .phase_i      (phase_q),
    .token_open_i (token_open_q),
    .byte_i       (s1_byte_q),
    .last_i       (s1_last_q),
    .res_o        (res)
  );

  // parse state update as a byte leaves the input register
  always_comb begin
    phase_d      = phase_q;
    token_open_d = token_open_q;
    if (s1_move) begin
      if (s1_last_q) begin
        phase_d      = PhMethod;
        token_open_d = 1'b0;
      end else begin
        phase_d      = res.next_phase;
        token_open_d = (res.cls != ClsSep);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhMethod;
      token_open_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      token_open_q <= token_open_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_byte_q  <= s1_byte_q;
      out_cls_q   <= res.cls;
      out_first_q <= res.first;
      out_last_q  <= s1_last_q;
      out_inc_q   <= res.incomplete;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign token_class_o = out_cls_q;
  assign token_first_o = out_first_q;
  assign out_last_o    = out_last_q;
  assign incomplete_o  = out_inc_q;

  // checks
  `HTTPTOK_ASSERT(a_inc_only_last, out_valid_q && out_inc_q |-> out_last_q, "incomplete on non-last byte")
  `HTTPTOK_ASSERT(a_sep_not_first, out_valid_q && (out_cls_q == ClsSep) |-> !out_first_q, "separator marked as token start")
  `HTTPTOK_ASSERT(a_last_restarts, s1_move && s1_last_q |=> (phase_q == PhMethod) && !token_open_q, "parser did not restart after last byte")
  `HTTPTOK_ASSERT(a_phase_onehot, $onehot(phase_q), "parse phase not one-hot")
  `HTTPTOK_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !out_valid_q && !s1_valid_q, "pipeline not empty after reset")

endmodule

// ===== sim/tb.sv =====
// testbench for http_request_tokenizer_core: drives request bytes, checks each labeled byte
// depends on httptok_pkg and the rtl of http_request_tokenizer_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import httptok_pkg::*;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam int unsigned NumDirected = 27;
  localparam int unsigned NumRandom = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAt = NumDirected + (NumRandom * 5) / 6;

  // one request byte with an optional hand-written expectation
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [2:0] cls;
    logic       first;
    logic       inc;
  } req_byte_t;

  // one labeled byte as it leaves the block
  typedef struct packed {
    logic [7:0] b;
    logic [2:0] cls;
    logic       first;
    logic       last;
    logic       inc;
  } label_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  logic [7:0] out_byte_o;
  logic [2:0] token_class_o;
  logic       token_first_o;
  logic       out_last_o;
  logic       incomplete_o;

  req_byte_t   stim_q[$];
  label_t      label_fifo[$];
  int unsigned n_err = 0;
  int unsigned n_acc = 0;
  int unsigned n_cycles = 0;
  int unsigned idle_mode = 0;
  int unsigned send_pct[3] = '{9, 81, 0};
  int unsigned recv_pct[3] = '{81, 9, 0};
  logic        hold_off = 1'b0;

  // tokenizer state mirrored by the predictor
  phase_e ph = PhMethod;
  logic   tok_open = 1'b0;

  http_request_tokenizer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .token_class_o(token_class_o),
    .token_first_o(token_first_o),
    .out_last_o   (out_last_o),
    .incomplete_o (incomplete_o)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // label one byte and advance the mirrored parse phase
  function automatic label_t label_byte(input logic [7:0] b, input logic last);
    label_t     lb;
    logic [2:0] cls;
    phase_e     nxt;
    nxt = ph;
    case (ph)
      PhPath: begin
        if (b == ChSpace) begin
          cls = ClsSep;
          nxt = PhVersion;
        end else begin
          cls = ClsPath;
        end
      end
      PhVersion: begin
        if (b == ChCr) begin
          cls = ClsSep;
          nxt = PhLineLf;
        end else begin
          cls = ClsVersion;
        end
      end
      PhLineLf: begin
        cls = ClsSep;
        nxt = PhLineStart;
      end
      PhLineStart: begin
        if (b == ChCr) begin
          cls = ClsSep;
          nxt = PhBlankLf;
        end else if (b == ChColon) begin
          cls = ClsSep;
          nxt = PhColonSkip;
        end else begin
          cls = ClsName;
          nxt = PhName;
        end
      end
      PhName: begin
        if (b == ChColon) begin
          cls = ClsSep;
          nxt = PhColonSkip;
        end else if (b == ChCr) begin
          cls = ClsSep;
          nxt = PhLineLf;
        end else begin
          cls = ClsName;
        end
      end
      PhColonSkip: begin
        cls = ClsSep;
        nxt = (b == ChCr) ? PhLineLf : PhValue;
      end
      PhValue: begin
        if (b == ChCr) begin
          cls = ClsSep;
          nxt = PhLineLf;
        end else begin
          cls = ClsValue;
        end
      end
      PhBlankLf: begin
        cls = ClsSep;
        nxt = PhBody;
      end
      PhBody: begin
        cls = ClsBody;
      end
      default: begin
        if (b == ChSpace) begin
          cls = ClsSep;
          nxt = PhPath;
        end else begin
          cls = ClsMethod;
          nxt = PhMethod;
        end
      end
    endcase
    lb.b = b;
    lb.cls = cls;
    lb.last = last;
    lb.inc = last && (nxt != PhBody);
    if (cls == ClsSep) begin
      lb.first = 1'b0;
      tok_open = 1'b0;
    end else begin
      lb.first = !tok_open;
      tok_open = 1'b1;
    end
    // last byte sends the parser back to the method
    if (last) begin
      ph = PhMethod;
      tok_open = 1'b0;
    end else begin
      ph = nxt;
    end
    return lb;
  endfunction

  // random byte, optionally avoiding space, cr and colon
  function automatic logic [7:0] pick_byte(input bit no_space, input bit no_cr,
                                           input bit no_colon);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((no_space && b == ChSpace) || (no_cr && b == ChCr) ||
               (no_colon && b == ChColon));
    return b;
  endfunction

  // line feed most of the time, any other byte now and then
  function automatic logic [7:0] lf_or_other();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return ChLf;
  endfunction

  // noise leaning on the bytes the parser reacts to
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return ChSpace;
      1: return ChCr;
      2: return ChLf;
      3: return ChColon;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_byte_t pr(input logic [7:0] b, input logic last);
    return '{b: b, last: last, typed: 1'b0, cls: ClsSep, first: 1'b0, inc: 1'b0};
  endfunction

  function automatic req_byte_t ck(input logic [7:0] b, input logic last,
                                   input logic [2:0] cls, input logic first,
                                   input logic inc);
    return '{b: b, last: last, typed: 1'b1, cls: cls, first: first, inc: inc};
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_err++;
    end
  endtask

  // receiver: random stall by phase, plus the long hold-off
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 99) < recv_pct[idle_mode]);
  end

  // long hold-off while the sender keeps offering bytes
  initial begin
    wait (n_acc == HoldAt);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // compare each output transfer with the oldest expected label
  always @(posedge clk_i) begin : check_labels
    label_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (label_fifo.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, actual byte %0h",
                 $time, out_byte_o);
        n_err++;
      end else begin
        want = label_fifo.pop_front();
        check_field("out_byte", want.b, out_byte_o);
        check_field("token_class", want.cls, token_class_o);
        check_field("token_first", want.first, token_first_o);
        check_field("out_last", want.last, out_last_o);
        check_field("incomplete", want.inc, incomplete_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus, prediction and end of run
  initial begin
    req_byte_t   dir_tbl[NumDirected];
    req_byte_t   row;
    label_t      lb;
    logic [7:0]  req_bytes[$];
    logic [7:0]  skip;
    int unsigned kind;
    int unsigned cut;
    int unsigned total;

    // directed request walking every phase and corner
    dir_tbl = '{
      ck(8'h47, 1'b0, ClsMethod, 1'b1, 1'b0),  // first byte after reset
      ck(8'hFF, 1'b0, ClsMethod, 1'b0, 1'b0),
      pr(ChSpace, 1'b0),
      pr(8'h00, 1'b0),
      pr(ChCr, 1'b0),                          // cr inside the path
      pr(ChSpace, 1'b0),
      pr(8'h48, 1'b0),
      pr(ChSpace, 1'b0),                       // space inside the version
      pr(ChCr, 1'b0),
      pr(8'h58, 1'b0),                         // byte after cr is not lf
      pr(8'h4E, 1'b0),
      pr(ChCr, 1'b0),                          // cr ends a bare header name
      pr(ChLf, 1'b0),
      pr(ChColon, 1'b0),                       // colon at line start
      pr(ChCr, 1'b0),                          // cr right after the colon
      pr(ChLf, 1'b0),
      pr(8'h4B, 1'b0),
      pr(ChColon, 1'b0),
      pr(ChSpace, 1'b0),
      pr(8'h76, 1'b0),
      pr(ChSpace, 1'b0),                       // space inside the value
      pr(ChCr, 1'b0),
      pr(ChLf, 1'b0),
      pr(ChCr, 1'b0),                          // blank line
      pr(ChLf, 1'b0),
      ck(8'h80, 1'b1, ClsBody, 1'b1, 1'b0),
      ck(8'h41, 1'b1, ClsMethod, 1'b1, 1'b1)   // lone last byte, never reached the body
    };
    foreach (dir_tbl[i]) stim_q = {stim_q, dir_tbl[i]};

    // random requests: mostly well formed, some cut short, some noise
    while (stim_q.size() < NumDirected + NumRandom) begin
      req_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        repeat ($urandom_range(1, 12)) req_bytes = {req_bytes, noise_byte()};
      end else begin
        // request line
        repeat ($urandom_range(1, 6)) req_bytes = {req_bytes, pick_byte(1, 0, 0)};
        req_bytes = {req_bytes, ChSpace};
        repeat ($urandom_range(1, 8)) req_bytes = {req_bytes, pick_byte(1, 0, 0)};
        req_bytes = {req_bytes, ChSpace};
        repeat ($urandom_range(1, 8)) req_bytes = {req_bytes, pick_byte(0, 1, 0)};
        req_bytes = {req_bytes, ChCr};
        req_bytes = {req_bytes, lf_or_other()};
        // header lines
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 7) != 0) begin
            repeat ($urandom_range(1, 6)) req_bytes = {req_bytes, pick_byte(0, 1, 1)};
          end
          if ($urandom_range(0, 7) == 0) begin
            req_bytes = {req_bytes, ChCr};
          end else begin
            req_bytes = {req_bytes, ChColon};
            case ($urandom_range(0, 7))
              0: skip = ChCr;
              1: skip = 8'($urandom_range(0, 255));
              default: skip = ChSpace;
            endcase
            req_bytes = {req_bytes, skip};
            if (skip != ChCr) begin
              repeat ($urandom_range(0, 8)) req_bytes = {req_bytes, pick_byte(0, 1, 0)};
              req_bytes = {req_bytes, ChCr};
            end
          end
          req_bytes = {req_bytes, lf_or_other()};
        end
        // blank line and body
        req_bytes = {req_bytes, ChCr};
        req_bytes = {req_bytes, lf_or_other()};
        repeat ($urandom_range(0, 8)) req_bytes = {req_bytes, 8'($urandom_range(0, 255))};
        if (kind < 30) begin
          cut = $urandom_range(0, req_bytes.size() - 1);
          req_bytes = req_bytes[0:cut];
        end
      end
      foreach (req_bytes[i]) stim_q = {stim_q, pr(req_bytes[i], i == req_bytes.size() - 1)};
    end
    total = stim_q.size();

    // reset
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // byte transfers; prediction happens at acceptance
    foreach (stim_q[i]) begin
      row = stim_q[i];
      if (i < NumDirected + (total - NumDirected) / 3) begin
        idle_mode = 0;
      end else if (i < NumDirected + 2 * (total - NumDirected) / 3) begin
        idle_mode = 1;
      end else begin
        idle_mode = 2;
      end
      while ($urandom_range(0, 99) < send_pct[idle_mode]) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i <= row.b;
      in_last_i <= row.last;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      lb = label_byte(row.b, row.last);
      if (row.typed) begin
        lb.cls = row.cls;
        lb.first = row.first;
        lb.inc = row.inc;
      end
      label_fifo = {label_fifo, lb};
      n_acc++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    // drain, then allow for the pipeline
    while (label_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== http_request_tokenizer_core.f =====
+incdir+rtl
rtl/httptok_pkg.sv
rtl/httptok_classify.sv
rtl/http_request_tokenizer_core.sv
sim/tb.sv
